// ===== hw/rtl/ipmi_kcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the KCS BMC-side engine.
package ipmi_kcs_pkg;

    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_PACKET_BYTES = 64;

    localparam logic [7:0] CMD_ABORT       = 8'h60;
    localparam logic [7:0] CMD_WRITE_START = 8'h61;
    localparam logic [7:0] CMD_WRITE_END   = 8'h62;
    localparam logic [7:0] CMD_READ        = 8'h68;

    localparam logic [7:0] ERR_NONE    = 8'h00;
    localparam logic [7:0] ERR_ABORTED = 8'h01;
    localparam logic [7:0] ERR_ILLEGAL = 8'h02;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [1:0] ABORT_NONE     = 2'd0;
    localparam logic [1:0] ABORT_STEP_ONE = 2'd2;
    localparam logic [1:0] ABORT_STEP_TWO = 2'd3;

    typedef enum logic [2:0] {
        OP_HOST_CMD  = 3'd0,
        OP_HOST_DATA = 3'd1,
        OP_LOAD      = 3'd2,
        OP_FETCH     = 3'd3,
        OP_READ_REQ  = 3'd4,
        OP_UNKNOWN   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WRITE     = 3'd1,
        PH_WRITE_END = 3'd2,
        PH_READ      = 3'd3,
        PH_ABORT     = 3'd4,
        PH_ERROR     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [0:0] channel;
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       last;
        logic [5:0] index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] host_state;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       request_ready;
        logic [6:0] request_length;
        logic [7:0] request_byte;
    } t_out_item;

    typedef struct packed {
        logic       absent;
        t_op        op;
        logic [0:0] channel;
        logic [7:0] data_byte;
        logic       last;
        logic [5:0] index;
    } t_cmd;

endpackage

// ===== hw/rtl/ipmi_kcs_front.sv =====
`timescale 1ns / 1ps
// Front end: decodes transactions and queues them for the back end.
module ipmi_kcs_front import ipmi_kcs_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    t_cmd       r_q [2];
    logic [1:0] r_count;
    logic       r_wr;
    logic       r_rd;
    t_cmd       dec;
    logic       push;
    logic       pop;

    always_comb begin
        dec.absent    = 32'(i_in_data.channel) >= NUM_CHANNELS;
        dec.channel   = i_in_data.channel;
        dec.data_byte = i_in_data.data_byte;
        dec.last      = i_in_data.last;
        dec.index     = i_in_data.index;
        case (i_in_data.operation)
            OP_HOST_CMD:  dec.op = OP_HOST_CMD;
            OP_HOST_DATA: dec.op = OP_HOST_DATA;
            OP_LOAD:      dec.op = OP_LOAD;
            OP_FETCH:     dec.op = OP_FETCH;
            OP_READ_REQ:  dec.op = OP_READ_REQ;
            default: dec.op = OP_UNKNOWN;
        endcase
    end

    assign o_in_ready  = r_count != 2'd2;
    assign o_cmd_valid = r_count != 2'd0;
    assign o_cmd       = r_q[r_rd];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= dec;
    end

endmodule

// ===== hw/rtl/ipmi_kcs_back.sv =====
`timescale 1ns / 1ps
// Back end: per-channel KCS phase logic, packet stores and result register.
module ipmi_kcs_back import ipmi_kcs_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW    = $clog2(PACKET_BYTES);
    localparam int CW    = $clog2(PACKET_BYTES + 1);
    localparam int MEMW  = CHW + AW;
    localparam int DEPTH = 1 << MEMW;

    t_phase       r_phase  [NUM_CHANNELS];
    logic [1:0]   r_astep  [NUM_CHANNELS];
    logic [7:0]   r_err    [NUM_CHANNELS];
    logic [1:0]   r_status [NUM_CHANNELS];
    logic [CW-1:0] r_rcount [NUM_CHANNELS];
    logic         r_rready [NUM_CHANNELS];
    logic [CW-1:0] r_spos   [NUM_CHANNELS];
    logic [CW-1:0] r_slen   [NUM_CHANNELS];
    logic [CW-1:0] r_lcount [NUM_CHANNELS];

    logic [7:0] r_rx_mem [DEPTH];
    logic [7:0] r_tx_mem [DEPTH];
    logic [7:0] r_rx_q;
    logic [7:0] r_tx_q;

    logic      r_valid;
    t_out_item r_out;
    logic      r_use_tx;
    logic      r_use_rx;

    logic [CHW-1:0] c;
    logic           adv;
    t_phase         n_phase;
    logic [1:0]     n_astep;
    logic [7:0]     n_err;
    logic [1:0]     n_status;
    logic [CW-1:0]  n_rcount;
    logic           n_rready;
    logic [CW-1:0]  n_spos;
    logic [CW-1:0]  n_slen;
    logic [CW-1:0]  n_lcount;
    t_out_item      n_out;
    logic           n_use_tx;
    logic           n_use_rx;
    logic           rx_we;
    logic           tx_we;
    logic [AW-1:0]  rx_waddr;
    logic [AW-1:0]  tx_waddr;
    logic [AW-1:0]  tx_raddr;
    logic [AW-1:0]  rx_raddr;
    logic           done;

    assign c           = CHW'(i_cmd.channel);
    assign adv         = i_cmd_valid && (!r_valid || i_out_ready);
    assign o_cmd_ready = !r_valid || i_out_ready;

    always_comb begin
        n_phase  = r_phase[c];
        n_astep  = r_astep[c];
        n_err    = r_err[c];
        n_status = r_status[c];
        n_rcount = r_rcount[c];
        n_rready = r_rready[c];
        n_spos   = r_spos[c];
        n_slen   = r_slen[c];
        n_lcount = r_lcount[c];
        n_out    = '0;
        n_use_tx = 1'b0;
        n_use_rx = 1'b0;
        rx_we    = 1'b0;
        tx_we    = 1'b0;
        rx_waddr = r_rcount[c][AW-1:0];
        tx_waddr = r_lcount[c][AW-1:0];
        tx_raddr = '0;
        rx_raddr = AW'(i_cmd.index);
        done     = r_spos[c] >= r_slen[c];
        case (i_cmd.op)
            OP_HOST_CMD: begin
                n_status = ST_WRITE;
                if (i_cmd.data_byte == CMD_WRITE_START) begin
                    n_rcount = '0;
                    n_phase  = PH_WRITE;
                end else if (i_cmd.data_byte == CMD_WRITE_END) begin
                    n_phase = PH_WRITE_END;
                end else if (i_cmd.data_byte == CMD_ABORT) begin
                    if (r_err[c] == ERR_NONE) n_err = ERR_ABORTED;
                    n_phase         = PH_ABORT;
                    n_astep         = ABORT_STEP_ONE;
                    n_out.out_valid = 1'b1;
                end else begin
                    n_err    = ERR_ILLEGAL;
                    n_status = ST_ERROR;
                    n_phase  = PH_ERROR;
                end
            end
            OP_HOST_DATA: begin
                case (r_phase[c])
                    PH_WRITE, PH_WRITE_END: begin
                        if (32'(r_rcount[c]) < PACKET_BYTES) begin
                            rx_we    = 1'b1;
                            n_rcount = r_rcount[c] + CW'(1);
                        end
                        if (r_phase[c] == PH_WRITE) begin
                            n_status = ST_WRITE;
                        end else begin
                            n_status = ST_READ;
                            n_phase  = PH_READ;
                            n_rready = 1'b1;
                        end
                    end
                    PH_READ: begin
                        n_out.out_valid = 1'b1;
                        if (done) n_status = ST_IDLE;
                        if (i_cmd.data_byte != CMD_READ) begin
                            n_status = ST_ERROR;
                        end else if (done) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_use_tx = 32'(r_spos[c]) < PACKET_BYTES;
                            tx_raddr = r_spos[c][AW-1:0];
                            n_spos   = r_spos[c] + CW'(1);
                        end
                    end
                    PH_ABORT: begin
                        if (r_astep[c] == ABORT_STEP_ONE) begin
                            n_status        = ST_READ;
                            n_out.out_valid = 1'b1;
                            n_out.out_byte  = r_err[c];
                            n_astep         = ABORT_STEP_TWO;
                        end else if (r_astep[c] == ABORT_STEP_TWO) begin
                            n_status        = ST_IDLE;
                            n_phase         = PH_IDLE;
                            n_astep         = ABORT_NONE;
                            n_out.out_valid = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_LOAD: begin
                if (32'(r_lcount[c]) < PACKET_BYTES) begin
                    tx_we    = 1'b1;
                    n_lcount = r_lcount[c] + CW'(1);
                end
                if (i_cmd.last) begin
                    n_slen          = n_lcount;
                    n_spos          = CW'(1);
                    n_lcount        = '0;
                    n_out.out_valid = 1'b1;
                    if (r_lcount[c] == '0) begin
                        n_out.out_byte = i_cmd.data_byte;
                    end else begin
                        n_use_tx = 1'b1;
                    end
                end
            end
            OP_FETCH: begin
                if (r_rready[c]) begin
                    n_rready             = 1'b0;
                    n_out.request_ready  = 1'b1;
                    n_out.request_length = 7'(r_rcount[c]);
                end
            end
            OP_READ_REQ: begin
                n_use_rx = 32'(i_cmd.index) < PACKET_BYTES;
            end
            default: ;
        endcase
        n_out.host_state = n_status;
        if (i_cmd.absent) begin
            n_out    = '0;
            n_use_tx = 1'b0;
            n_use_rx = 1'b0;
            rx_we    = 1'b0;
            tx_we    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_phase[k]  <= PH_IDLE;
                r_astep[k]  <= ABORT_NONE;
                r_err[k]    <= ERR_NONE;
                r_status[k] <= ST_ERROR;
                r_rcount[k] <= '0;
                r_rready[k] <= 1'b0;
                r_spos[k]   <= '0;
                r_slen[k]   <= '0;
                r_lcount[k] <= '0;
            end
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (adv && !i_cmd.absent) begin
                r_phase[c]  <= n_phase;
                r_astep[c]  <= n_astep;
                r_err[c]    <= n_err;
                r_status[c] <= n_status;
                r_rcount[c] <= n_rcount;
                r_rready[c] <= n_rready;
                r_spos[c]   <= n_spos;
                r_slen[c]   <= n_slen;
                r_lcount[c] <= n_lcount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out    <= n_out;
            r_use_tx <= n_use_tx;
            r_use_rx <= n_use_rx;
            r_tx_q   <= r_tx_mem[{c, tx_raddr}];
            r_rx_q   <= r_rx_mem[{c, rx_raddr}];
            if (rx_we) r_rx_mem[{c, rx_waddr}] <= i_cmd.data_byte;
            if (tx_we) r_tx_mem[{c, tx_waddr}] <= i_cmd.data_byte;
        end
    end

    always_comb begin
        o_out_data = r_out;
        if (r_use_tx) o_out_data.out_byte = r_tx_q;
        if (r_use_rx) o_out_data.request_byte = r_rx_q;
    end

    assign o_out_valid = r_valid;

endmodule

// ===== hw/rtl/ipmi_kcs_bmc_side_engine.sv =====
`timescale 1ns / 1ps
// Top level of the KCS BMC-side engine: decode queue and execution back end.
// Path: each input transaction passes through a queue slot in the front end, then is executed
// into the result register of the back end.
// Throughput: one transaction per cycle while i_out_ready lets results drain, set by the execute
// stage and the registered read port of each packet store; a held result stalls the queue.
// Reset: synchronous, active low; every channel returns to idle phase with error status.
// Packet stores are not cleared; no clearing pass is run.
module ipmi_kcs_bmc_side_engine import ipmi_kcs_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    ipmi_kcs_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready),
        .o_cmd      (cmd)
    );

    ipmi_kcs_back #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .PACKET_BYTES(PACKET_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    a_no_byte_without_obf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_valid |-> o_out_data.out_byte == 8'd0)
        else $error("out_byte set without OBF");

    a_length_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.request_ready |-> o_out_data.request_length == 7'd0)
        else $error("request_length without request_ready");

    a_fetch_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.request_ready
        |-> !o_out_data.out_valid && o_out_data.request_byte == 8'd0)
        else $error("fetch result mixed with other results");

endmodule

// ===== tb/sv/ipmi_kcs_bmc_side_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the KCS BMC-side engine: directed table, then random sequences.
module ipmi_kcs_bmc_side_engine_test import ipmi_kcs_pkg::*;;

    localparam int NCH      = DEF_NUM_CHANNELS;
    localparam int PKT      = DEF_PACKET_BYTES;
    localparam int N_ITEMS  = 1400;
    localparam int WD_LIMIT = 5000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    ipmi_kcs_bmc_side_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // channel model
    t_phase     kcs_phase   [NCH];
    logic [1:0] kcs_astep   [NCH];
    logic [7:0] kcs_err     [NCH];
    logic [1:0] kcs_status  [NCH];
    int         rx_count    [NCH];
    bit         rx_ready    [NCH];
    logic [7:0] rx_buf      [NCH][PKT];
    bit         rx_written  [NCH][PKT];
    logic [7:0] tx_buf      [NCH][PKT];
    int         tx_pos      [NCH];
    int         tx_len      [NCH];
    int         load_cnt    [NCH];

    t_out_item  pending_results[$];
    int         n_errors;
    int         n_sent;
    int         n_results;
    int         n_emitted;
    int         idle_cycles;
    int         tx_idle_pct;
    int         rx_idle_pct;

    t_in_item   dir_in[$];
    bit         dir_typed[$];
    t_out_item  dir_exp[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_in_item mk(bit ch, logic [2:0] op, logic [7:0] b,
                                    bit lst = 1'b0, logic [5:0] idx = '0);
        t_in_item it;
        it.channel   = ch;
        it.operation = op;
        it.data_byte = b;
        it.last      = lst;
        it.index     = idx;
        return it;
    endfunction

    function automatic t_out_item res(logic [1:0] st, bit ov = 1'b0, logic [7:0] ob = '0);
        t_out_item r;
        r = '0;
        r.host_state = st;
        r.out_valid  = ov;
        r.out_byte   = ob;
        return r;
    endfunction

    function automatic void reset_model();
        for (int c = 0; c < NCH; c++) begin
            kcs_phase[c]  = PH_IDLE;
            kcs_astep[c]  = ABORT_NONE;
            kcs_err[c]    = ERR_NONE;
            kcs_status[c] = ST_ERROR;
            rx_count[c]   = 0;
            rx_ready[c]   = 1'b0;
            tx_pos[c]     = 0;
            tx_len[c]     = 0;
            load_cnt[c]   = 0;
            for (int i = 0; i < PKT; i++) rx_written[c][i] = 1'b0;
        end
    endfunction

    function automatic void store_request(int ch, logic [7:0] b);
        if (rx_count[ch] < PKT) begin
            rx_buf[ch][rx_count[ch]]     = b;
            rx_written[ch][rx_count[ch]] = 1'b1;
            rx_count[ch]++;
        end
    endfunction

    function automatic t_out_item predict_kcs(t_in_item it);
        t_out_item r;
        int        ch;
        logic [7:0] b;
        bit        done;
        r  = '0;
        ch = it.channel;
        b  = it.data_byte;
        case (it.operation)
            OP_HOST_CMD: begin
                kcs_status[ch] = ST_WRITE;
                if (b == CMD_WRITE_START) begin
                    rx_count[ch]  = 0;
                    kcs_phase[ch] = PH_WRITE;
                end else if (b == CMD_WRITE_END) begin
                    kcs_phase[ch] = PH_WRITE_END;
                end else if (b == CMD_ABORT) begin
                    if (kcs_err[ch] == ERR_NONE) kcs_err[ch] = ERR_ABORTED;
                    kcs_phase[ch] = PH_ABORT;
                    kcs_astep[ch] = ABORT_STEP_ONE;
                    r.out_valid   = 1'b1;
                end else begin
                    kcs_err[ch]    = ERR_ILLEGAL;
                    kcs_status[ch] = ST_ERROR;
                    kcs_phase[ch]  = PH_ERROR;
                end
            end
            OP_HOST_DATA: begin
                case (kcs_phase[ch])
                    PH_WRITE: begin
                        kcs_status[ch] = ST_WRITE;
                        store_request(ch, b);
                    end
                    PH_WRITE_END: begin
                        kcs_status[ch] = ST_READ;
                        store_request(ch, b);
                        kcs_phase[ch] = PH_READ;
                        rx_ready[ch]  = 1'b1;
                    end
                    PH_READ: begin
                        done = tx_pos[ch] >= tx_len[ch];
                        if (done) kcs_status[ch] = ST_IDLE;
                        r.out_valid = 1'b1;
                        if (b != CMD_READ) begin
                            kcs_status[ch] = ST_ERROR;
                        end else if (done) begin
                            kcs_phase[ch] = PH_IDLE;
                        end else begin
                            r.out_byte = tx_buf[ch][tx_pos[ch]];
                            tx_pos[ch]++;
                        end
                    end
                    PH_ABORT: begin
                        if (kcs_astep[ch] == ABORT_STEP_ONE) begin
                            kcs_status[ch] = ST_READ;
                            r.out_valid    = 1'b1;
                            r.out_byte     = kcs_err[ch];
                            kcs_astep[ch]  = ABORT_STEP_TWO;
                        end else if (kcs_astep[ch] == ABORT_STEP_TWO) begin
                            kcs_status[ch] = ST_IDLE;
                            kcs_phase[ch]  = PH_IDLE;
                            kcs_astep[ch]  = ABORT_NONE;
                            r.out_valid    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_LOAD: begin
                if (load_cnt[ch] < PKT) begin
                    tx_buf[ch][load_cnt[ch]] = b;
                    load_cnt[ch]++;
                end
                if (it.last) begin
                    tx_len[ch]   = load_cnt[ch];
                    tx_pos[ch]   = 1;
                    load_cnt[ch] = 0;
                    r.out_valid  = 1'b1;
                    r.out_byte   = tx_buf[ch][0];
                end
            end
            OP_FETCH: begin
                if (rx_ready[ch]) begin
                    rx_ready[ch]     = 1'b0;
                    r.request_ready  = 1'b1;
                    r.request_length = rx_count[ch][6:0];
                end
            end
            OP_READ_REQ: r.request_byte = rx_buf[ch][it.index];
            default: ;
        endcase
        r.host_state = kcs_status[ch];
        return r;
    endfunction

    task automatic report(string field, logic [7:0] got, logic [7:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        n_errors++;
    endtask

    task automatic send_item(t_in_item it, bit typed = 1'b0, t_out_item want = '0);
        t_out_item pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_kcs(it);
        pending_results.push_back(typed ? want : pred);
        n_sent++;
        if (n_sent == N_ITEMS / 3) begin
            tx_idle_pct = 49;
            rx_idle_pct = 38;
        end else if (n_sent == 2 * N_ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    function automatic logic [5:0] written_index(int ch);
        logic [5:0] idx;
        do idx = 6'($urandom_range(0, PKT - 1)); while (!rx_written[ch][idx]);
        return idx;
    endfunction

    task automatic run_transfer(bit ch);
        int n;
        int m;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        send_item(mk(ch, OP_HOST_CMD, CMD_WRITE_START));
        for (int i = 0; i < n - 1; i++)
            send_item(mk(ch, OP_HOST_DATA, 8'($urandom_range(0, 255))));
        send_item(mk(ch, OP_HOST_CMD, CMD_WRITE_END));
        send_item(mk(ch, OP_HOST_DATA, 8'($urandom_range(0, 255))));
        send_item(mk(ch, OP_FETCH, 8'($urandom_range(0, 255))));
        repeat ($urandom_range(0, 3))
            send_item(mk(ch, OP_READ_REQ, 8'($urandom_range(0, 255)), 1'b0,
                         written_index(ch)));
        if ($urandom_range(0, 9) == 0) begin
            send_item(mk(ch, OP_HOST_CMD, CMD_ABORT));
            send_item(mk(ch, OP_HOST_DATA, 8'($urandom_range(0, 255))));
            send_item(mk(ch, OP_HOST_DATA, 8'($urandom_range(0, 255))));
            return;
        end
        m = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (int i = 0; i < m; i++)
            send_item(mk(ch, OP_LOAD, 8'($urandom_range(0, 255)), i == m - 1));
        for (int i = 0; i < m + 1; i++)
            send_item(mk(ch, OP_HOST_DATA,
                         ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : CMD_READ));
    endtask

    task automatic run_noise();
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'($urandom));
        if ($urandom_range(0, 3) == 0) it.data_byte = 8'(CMD_ABORT + $urandom_range(0, 8));
        if (it.operation == OP_READ_REQ && !rx_written[it.channel][it.index]) begin
            if (rx_written[it.channel][0]) it.index = '0;
            else it.operation = OP_FETCH;
        end
        send_item(it);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(0, 99) >= rx_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("[%0t] unexpected result 0x%0h", $time, o_out_data);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.out_valid) n_emitted++;
                if (o_out_data.host_state !== want.host_state)
                    report("host_state", o_out_data.host_state, want.host_state);
                if (o_out_data.out_valid !== want.out_valid)
                    report("out_valid", o_out_data.out_valid, want.out_valid);
                if (o_out_data.out_byte !== want.out_byte)
                    report("out_byte", o_out_data.out_byte, want.out_byte);
                if (o_out_data.request_ready !== want.request_ready)
                    report("request_ready", o_out_data.request_ready, want.request_ready);
                if (o_out_data.request_length !== want.request_length)
                    report("request_length", o_out_data.request_length, want.request_length);
                if (o_out_data.request_byte !== want.request_byte)
                    report("request_byte", o_out_data.request_byte, want.request_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WD_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        n_errors    = 0;
        n_sent      = 0;
        n_results   = 0;
        n_emitted   = 0;
        idle_cycles = 0;
        tx_idle_pct = 38;
        rx_idle_pct = 49;
        reset_model();

        dir_in = '{
            mk(0, OP_FETCH, 8'h00),
            mk(0, OP_HOST_CMD, 8'h00),
            mk(0, OP_HOST_CMD, CMD_ABORT),
            mk(0, OP_HOST_DATA, 8'hFF),
            mk(0, OP_HOST_DATA, 8'h00),
            mk(0, OP_HOST_DATA, 8'h55),
            mk(1, OP_HOST_CMD, CMD_ABORT),
            mk(1, OP_HOST_DATA, 8'h00),
            mk(1, OP_HOST_DATA, 8'hFF),
            mk(1, OP_HOST_CMD, CMD_WRITE_START),
            mk(1, OP_HOST_DATA, 8'hFF),
            mk(1, OP_HOST_CMD, CMD_WRITE_END),
            mk(1, OP_HOST_DATA, 8'h00),
            mk(1, OP_FETCH, 8'h00),
            mk(1, OP_READ_REQ, 8'h00, 0, 6'd0),
            mk(1, OP_READ_REQ, 8'hFF, 1, 6'd1),
            mk(1, OP_LOAD, 8'hA5, 0),
            mk(1, OP_LOAD, 8'h5A, 1),
            mk(1, OP_HOST_DATA, 8'h13),
            mk(1, OP_HOST_DATA, CMD_READ),
            mk(1, OP_HOST_DATA, CMD_READ),
            mk(0, 3'd5, 8'hFF, 1, 6'h3F),
            mk(0, 3'd7, 8'h00),
            mk(0, OP_HOST_CMD, 8'hFF),
            mk(0, OP_HOST_DATA, 8'h68)
        };
        dir_typed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                      0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};
        dir_exp = '{
            res(ST_ERROR), res(ST_ERROR), res(ST_WRITE, 1, 8'h00),
            res(ST_READ, 1, ERR_ILLEGAL), res(ST_IDLE, 1, 8'h00), res(ST_IDLE),
            res(ST_WRITE, 1, 8'h00), res(ST_READ, 1, ERR_ABORTED), res(ST_IDLE, 1, 8'h00),
            res(ST_WRITE), res(ST_WRITE), res(ST_WRITE), res(ST_READ),
            '0, '0, '0, '0, '0, res(ST_ERROR, 1, 8'h00),
            '0, '0, '0, '0, res(ST_ERROR), '0
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_in[i]) send_item(dir_in[i], dir_typed[i], dir_exp[i]);

        while (n_sent < N_ITEMS) begin
            if ($urandom_range(0, 3) != 0) run_transfer(1'($urandom_range(0, 1)));
            else repeat ($urandom_range(1, 6)) run_noise();
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d transactions in, %0d results out, %0d host bytes placed",
                 n_sent, n_results, n_emitted);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
